[rtl/core/fec_pkg.sv]
// Shared types and constants for the framed CRC-16 byte encoder.
package fec_pkg;

   localparam int unsigned MAX_PAYLOAD = 255;
   localparam int unsigned HEADER_BYTES = 7;
   localparam int unsigned CRC_BYTES = 2;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic [8:0] KIND_LIMIT_RESET = 9'd256;
   localparam logic [8:0] TYPE_LIMIT_RESET = 9'd256;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_REG_CAPACITY = 2'd0,
      CSR_REG_KIND_LIMIT = 2'd1,
      CSR_REG_TYPE_LIMIT = 2'd2,
      CSR_REG_NONE = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BUFFER = 2'd1,
      STATUS_KIND = 2'd2,
      STATUS_TYPE = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] capacity;
      logic [8:0] kind_limit;
      logic [8:0] type_limit;
   } cfg_type;

   typedef struct packed {
      logic mode;
      logic [7:0] frame_version;
      logic [7:0] package_kind;
      logic [7:0] flag_bits;
      logic [7:0] reserved_byte;
      logic [15:0] sequence_number;
      logic [7:0] message_type;
      logic [7:0] payload_length;
      logic [7:0] payload_byte;
   } item_type;

   typedef struct packed {
      logic valid;
      logic [7:0] out_byte;
      status_type status;
      logic last;
   } emit_type;

endpackage

[rtl/core/frame_encoder_crc16.sv]
// Top level: frame encoder emitting header, payload and CRC-16/CCITT-FALSE bytes.
// Each beat passes from the item register through the result register to rsp.
// One payload byte per cycle while rsp is not stalled; the final payload byte adds the
// two CRC bytes, a valid header gives seven bytes (nine when the length is zero), a rejected
// header one status beat; the single result register passes one byte per unstalled cycle.
// Reset is synchronous: no frame open, CRC at 0xFFFF, registers at 65535/256/256.
module frame_encoder_crc16
   import fec_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_mode,
   input logic [7:0] req_frame_version,
   input logic [7:0] req_package_kind,
   input logic [7:0] req_flag_bits,
   input logic [7:0] req_reserved_byte,
   input logic [15:0] req_sequence_number,
   input logic [7:0] req_message_type,
   input logic [7:0] req_payload_length,
   input logic [7:0] req_payload_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic rsp_last,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic pready
);

   cfg_type cfg;
   item_type req_item;
   emit_type emit;
   logic out_ok;

   assign req_item.mode = req_mode;
   assign req_item.frame_version = req_frame_version;
   assign req_item.package_kind = req_package_kind;
   assign req_item.flag_bits = req_flag_bits;
   assign req_item.reserved_byte = req_reserved_byte;
   assign req_item.sequence_number = req_sequence_number;
   assign req_item.message_type = req_message_type;
   assign req_item.payload_length = req_payload_length;
   assign req_item.payload_byte = req_payload_byte;

   fec_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .cfg(cfg)
   );

   fec_seq u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .cfg(cfg),
      .out_ok(out_ok),
      .emit(emit)
   );

   fec_out u_out (
      .clock(clock),
      .reset(reset),
      .emit(emit),
      .out_ok(out_ok),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

endmodule

[rtl/core/fec_csr.sv]
// Configuration register bank behind the APB-style port.
module fec_csr
   import fec_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic pready,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   csr_reg_type reg_sel;
   logic wr_en;

   assign reg_sel = csr_reg_type'(paddr[3:2]);
   assign wr_en = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_sel)
         CSR_REG_CAPACITY: begin
            prdata = {16'd0, cfg_ff.capacity};
            if (wr_en) begin
               cfg_in.capacity = pwdata[15:0];
            end
         end
         CSR_REG_KIND_LIMIT: begin
            prdata = {23'd0, cfg_ff.kind_limit};
            if (wr_en) begin
               cfg_in.kind_limit = pwdata[8:0];
            end
         end
         CSR_REG_TYPE_LIMIT: begin
            prdata = {23'd0, cfg_ff.type_limit};
            if (wr_en) begin
               cfg_in.type_limit = pwdata[8:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity <= CAPACITY_RESET;
         cfg_ff.kind_limit <= KIND_LIMIT_RESET;
         cfg_ff.type_limit <= TYPE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/fec_seq.sv]
// Input item register, frame state, CRC and per-item result sequencing.
module fec_seq
   import fec_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input item_type req_item,
   input cfg_type cfg,
   input logic out_ok,
   output emit_type emit
);

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   item_type item_ff;
   logic item_valid_ff, item_valid_in;
   logic [3:0] step_ff, step_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] remaining_ff, remaining_in;
   logic active_ff, active_in;
   logic discarding_ff, discarding_in;

   status_type hdr_status;
   logic [16:0] needed;
   logic [7:0] hdr_byte;
   logic [15:0] crc_base;
   logic last_step;
   logic advance;
   logic take;

   assign needed = {9'd0, item_ff.payload_length} + 17'(HEADER_BYTES + CRC_BYTES);

   always_comb begin
      if ({8'd0, item_ff.payload_length} > 16'(MAX_PAYLOAD)
          || {1'b0, cfg.capacity} < needed) begin
         hdr_status = STATUS_BUFFER;
      end else if ({1'b0, item_ff.package_kind} >= cfg.kind_limit) begin
         hdr_status = STATUS_KIND;
      end else if ({1'b0, item_ff.message_type} >= cfg.type_limit) begin
         hdr_status = STATUS_TYPE;
      end else begin
         hdr_status = STATUS_OK;
      end
   end

   always_comb begin
      unique case (step_ff)
         4'd0: hdr_byte = item_ff.frame_version;
         4'd1: hdr_byte = item_ff.package_kind;
         4'd2: hdr_byte = item_ff.flag_bits;
         4'd3: hdr_byte = item_ff.reserved_byte;
         4'd4: hdr_byte = item_ff.sequence_number[15:8];
         4'd5: hdr_byte = item_ff.sequence_number[7:0];
         default: hdr_byte = item_ff.message_type;
      endcase
   end

   always_comb begin
      emit = '0;
      emit.status = STATUS_OK;
      last_step = 1'b1;
      crc_in = crc_ff;
      remaining_in = remaining_ff;
      active_in = active_ff;
      discarding_in = discarding_ff;
      crc_base = (step_ff == 4'd0) ? CRC_INIT : crc_ff;
      if (!item_ff.mode) begin
         if (step_ff == 4'd0 && hdr_status != STATUS_OK) begin
            emit.valid = 1'b1;
            emit.status = hdr_status;
            emit.last = 1'b1;
            discarding_in = (item_ff.payload_length != 8'd0);
            remaining_in = item_ff.payload_length;
            active_in = 1'b0;
            crc_in = CRC_INIT;
         end else if (step_ff <= 4'd6) begin
            emit.valid = 1'b1;
            emit.out_byte = hdr_byte;
            crc_in = crc16_update(crc_base, hdr_byte);
            last_step = 1'b0;
            if (step_ff == 4'd0) begin
               active_in = 1'b0;
               discarding_in = 1'b0;
               remaining_in = 8'd0;
            end
            if (step_ff == 4'd6 && item_ff.payload_length != 8'd0) begin
               last_step = 1'b1;
               active_in = 1'b1;
               remaining_in = item_ff.payload_length;
            end
         end else if (step_ff == 4'd7) begin
            emit.valid = 1'b1;
            emit.out_byte = crc_ff[15:8];
            last_step = 1'b0;
         end else begin
            emit.valid = 1'b1;
            emit.out_byte = crc_ff[7:0];
            emit.last = 1'b1;
            crc_in = CRC_INIT;
            active_in = 1'b0;
         end
      end else begin
         if (step_ff == 4'd0) begin
            if (discarding_ff) begin
               if (remaining_ff != 8'd0) begin
                  remaining_in = remaining_ff - 8'd1;
               end
               if (remaining_ff <= 8'd1) begin
                  discarding_in = 1'b0;
               end
            end else if (!active_ff || remaining_ff == 8'd0) begin
               active_in = 1'b0;
            end else begin
               emit.valid = 1'b1;
               emit.out_byte = item_ff.payload_byte;
               crc_in = crc16_update(crc_ff, item_ff.payload_byte);
               remaining_in = remaining_ff - 8'd1;
               last_step = (remaining_ff != 8'd1);
            end
         end else if (step_ff == 4'd1) begin
            emit.valid = 1'b1;
            emit.out_byte = crc_ff[15:8];
            last_step = 1'b0;
         end else begin
            emit.valid = 1'b1;
            emit.out_byte = crc_ff[7:0];
            emit.last = 1'b1;
            crc_in = CRC_INIT;
            active_in = 1'b0;
         end
      end
      emit.valid = emit.valid & item_valid_ff;
   end

   assign advance = item_valid_ff & (!emit.valid | out_ok);
   assign req_stall = item_valid_ff & !(advance & last_step);
   assign take = req_valid & !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      step_in = step_ff;
      if (advance) begin
         step_in = last_step ? 4'd0 : step_ff + 4'd1;
         if (last_step) begin
            item_valid_in = 1'b0;
         end
      end
      if (take) begin
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff <= 4'd0;
         crc_ff <= CRC_INIT;
         remaining_ff <= 8'd0;
         active_ff <= 1'b0;
         discarding_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff <= step_in;
         if (advance) begin
            crc_ff <= crc_in;
            remaining_ff <= remaining_in;
            active_ff <= active_in;
            discarding_ff <= discarding_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(active_ff && discarding_ff))
      else $error("frame open and dropping at the same time");

   a_active_count: assert property (@(posedge clock) disable iff (reset)
      active_ff && step_ff == 4'd0 |-> remaining_ff != 8'd0)
      else $error("open frame with no payload bytes left");

   a_idle_crc: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff && !active_ff |-> crc_ff == CRC_INIT)
      else $error("CRC not back at its initial value between frames");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && item_ff.mode |-> step_ff <= 4'd2)
      else $error("payload beat sequencing past its CRC bytes");

endmodule

[rtl/core/fec_out.sv]
// Result register that holds one output beat until it is taken.
module fec_out
   import fec_pkg::*;
(
   input logic clock,
   input logic reset,
   input emit_type emit,
   output logic out_ok,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic rsp_last
);

   logic valid_ff;
   logic [7:0] byte_ff;
   status_type status_ff;
   logic last_ff;

   assign out_ok = !valid_ff | !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_status = status_ff;
   assign rsp_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ok) begin
         valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ok && emit.valid) begin
         byte_ff <= emit.out_byte;
         status_ff <= emit.status;
         last_ff <= emit.last;
      end
   end

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != STATUS_OK |-> last_ff && byte_ff == 8'd0)
      else $error("error beat without last or with a nonzero byte");

endmodule
